>>> rtl/keyword_substitution_cipher_unit_macros.svh
// ----------------------------------------------------------------------------
// Keyword substitution cipher: assertion macros
// Shorthand for clocked, reset-qualified checks used in the cipher RTL.
// ----------------------------------------------------------------------------
`ifndef KEYWORD_SUBSTITUTION_CIPHER_UNIT_MACROS_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define KSCU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define KSCU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/kscu_pkg.sv
// ----------------------------------------------------------------------------
// Keyword substitution cipher package
// Shared types and constants for the front end, command queue and back end.
// ----------------------------------------------------------------------------
package kscu_pkg;

  localparam int NUM_LETTERS = 26;
  localparam int LETTER_W    = 5;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [LETTER_W-1:0] LETTER_CNT  = 5'd26;
  localparam logic [LETTER_W-1:0] LAST_LETTER = 5'd25;

  localparam logic [7:0] CHAR_LO_A = 8'h61;
  localparam logic [7:0] CHAR_LO_Z = 8'h7a;
  localparam logic [7:0] CHAR_UP_A = 8'h41;
  localparam logic [7:0] CHAR_UP_Z = 8'h5a;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_KEY   = 2'd1,
    OP_END   = 2'd2,
    OP_MSG   = 2'd3
  } op_e;

  typedef enum logic {
    BK_RUN  = 1'b0,
    BK_FILL = 1'b1
  } back_state_e;

  // Decoded item as it travels from the front end to the back end.
  typedef struct packed {
    op_e                 op;
    logic                is_letter;
    logic                upper;
    logic [LETTER_W-1:0] idx;
    logic [7:0]          raw;
  } cmd_t;

  typedef struct packed {
    logic                filling;
    logic                complete;
    logic [LETTER_W-1:0] key_count;
  } back_status_t;

endpackage

>>> rtl/kscu_front.sv
// ----------------------------------------------------------------------------
// Keyword substitution cipher: front end
// Takes input transfers and decodes the byte into letter index and case.
// ----------------------------------------------------------------------------
module kscu_front (
  input  logic [1:0]    op_i,
  input  logic [7:0]    char_in_i,
  input  logic          push_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output kscu_pkg::cmd_t cmd_o
);
  import kscu_pkg::*;

  logic is_lo;
  logic is_up;

  assign is_lo = (char_in_i >= CHAR_LO_A) && (char_in_i <= CHAR_LO_Z);
  assign is_up = (char_in_i >= CHAR_UP_A) && (char_in_i <= CHAR_UP_Z);

  always_comb begin
    cmd_o.op        = op_e'(op_i);
    cmd_o.is_letter = is_lo || is_up;
    cmd_o.upper     = is_up;
    cmd_o.raw       = char_in_i;
    // Non-letters carry index 0 so the table lookup stays in range.
    if (is_lo) begin
      cmd_o.idx = LETTER_W'(char_in_i - CHAR_LO_A);
    end else if (is_up) begin
      cmd_o.idx = LETTER_W'(char_in_i - CHAR_UP_A);
    end else begin
      cmd_o.idx = '0;
    end
  end

  assign q_push_o = push_i && !q_full_i;

endmodule

>>> rtl/kscu_queue.sv
// ----------------------------------------------------------------------------
// Keyword substitution cipher: command queue
// Small FIFO of decoded commands between the front end and the back end.
// ----------------------------------------------------------------------------
module kscu_queue #(
  parameter int Depth = kscu_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  kscu_pkg::cmd_t data_i,
  input  logic           pop_i,
  output kscu_pkg::cmd_t head_o,
  output logic           full_o,
  output logic           empty_o
);
  import kscu_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/kscu_back.sv
// ----------------------------------------------------------------------------
// Keyword substitution cipher: back end
// Builds the substitution table from key letters, sweeps the alphabet to
// complete it, and enciphers message letters into a one-entry result register.
// ----------------------------------------------------------------------------
module kscu_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  kscu_pkg::cmd_t         head_i,
  input  logic                   q_empty_i,
  output logic                   q_pop_o,
  input  logic                   res_pop_i,
  output logic                   res_valid_o,
  output logic [7:0]             res_char_o,
  output kscu_pkg::back_status_t status_o
);
  import kscu_pkg::*;

  back_state_e         state_q, state_d;
  logic [NUM_LETTERS-1:0] used_q, used_d;
  logic [LETTER_W-1:0] count_q, count_d;
  logic                complete_q, complete_d;
  logic [LETTER_W-1:0] fill_q, fill_d;
  logic                out_valid_q, out_valid_d;
  logic [7:0]          out_char_q, out_char_d;
  logic [LETTER_W-1:0] table_q [NUM_LETTERS];
  logic                tbl_we;
  logic [LETTER_W-1:0] tbl_wdata;
  logic                slot_free;
  logic [7:0]          case_base;

  assign slot_free = !out_valid_q || res_pop_i;
  assign case_base = head_i.upper ? CHAR_UP_A : CHAR_LO_A;

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    count_d     = count_q;
    complete_d  = complete_q;
    fill_d      = fill_q;
    out_valid_d = out_valid_q && !res_pop_i;
    out_char_d  = out_char_q;
    q_pop_o     = 1'b0;
    tbl_we      = 1'b0;
    tbl_wdata   = head_i.idx;
    case (state_q)
      BK_RUN: begin
        if (!q_empty_i) begin
          case (head_i.op)
            OP_START: begin
              used_d     = '0;
              count_d    = '0;
              complete_d = 1'b0;
              q_pop_o    = 1'b1;
            end
            OP_KEY: begin
              q_pop_o = 1'b1;
              if (!complete_q && head_i.is_letter && (count_q < LETTER_CNT) &&
                  !used_q[head_i.idx]) begin
                used_d[head_i.idx] = 1'b1;
                tbl_we             = 1'b1;
                count_d            = count_q + 1'b1;
              end
            end
            OP_END: begin
              if (!complete_q) begin
                state_d = BK_FILL;
                fill_d  = '0;
              end else begin
                q_pop_o = 1'b1;
              end
            end
            OP_MSG: begin
              // An incomplete table is swept first; the message stays at the head.
              if (!complete_q) begin
                state_d = BK_FILL;
                fill_d  = '0;
              end else if (slot_free) begin
                q_pop_o     = 1'b1;
                out_valid_d = 1'b1;
                out_char_d  = head_i.is_letter ?
                              case_base + {3'b000, table_q[head_i.idx]} : head_i.raw;
              end
            end
            default: ;
          endcase
        end
      end
      BK_FILL: begin
        tbl_wdata = fill_q;
        if (!used_q[fill_q] && (count_q < LETTER_CNT)) begin
          tbl_we  = 1'b1;
          count_d = count_q + 1'b1;
        end
        if (fill_q == LAST_LETTER) begin
          state_d    = BK_RUN;
          complete_d = 1'b1;
        end else begin
          fill_d = fill_q + 1'b1;
        end
      end
      default: state_d = BK_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_RUN;
      used_q      <= '0;
      count_q     <= '0;
      complete_q  <= 1'b1;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      count_q     <= count_d;
      complete_q  <= complete_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
  end

  // Table comes out of reset as the identity mapping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LETTERS; i++) begin
        table_q[i] <= LETTER_W'(i);
      end
    end else if (tbl_we) begin
      table_q[count_q] <= tbl_wdata;
    end
  end

  assign res_valid_o        = out_valid_q;
  assign res_char_o         = out_char_q;
  assign status_o.filling   = (state_q == BK_FILL);
  assign status_o.complete  = complete_q;
  assign status_o.key_count = count_q;

endmodule

>>> rtl/keyword_substitution_cipher_unit.sv
// ----------------------------------------------------------------------------
// Keyword substitution cipher unit
// Keyed substitution of ASCII letters; key letters build the table, message
// letters are enciphered, other message bytes pass through.
// ----------------------------------------------------------------------------
//  Channel   Handshake       Payload
//  -------   -------------   -------------------------------
//  input     push / full      op_i[1:0], char_in_i[7:0]
//  result    pop / empty      char_out_o[7:0] (message bytes only)
//
// Start, key and message bytes are handled one per cycle by the back end, a
// message byte only while the result slot is free. The end of an unfinished
// key, or a message after one, first sweeps the alphabet to finish the table.
// The command queue keeps accepting input during the sweep until it fills.
// Reset leaves the identity table in place; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "keyword_substitution_cipher_unit_macros.svh"

module keyword_substitution_cipher_unit #(
  parameter int QueueDepth = kscu_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [1:0] op_i,
  input  logic [7:0] char_in_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] char_out_o
);
  import kscu_pkg::*;

  cmd_t         fe_cmd;
  cmd_t         q_head;
  logic         fe_push;
  logic         q_full;
  logic         q_empty;
  logic         q_pop;
  logic         res_valid;
  back_status_t bk_status;

  kscu_front u_front (
    .op_i      (op_i),
    .char_in_i (char_in_i),
    .push_i    (push),
    .q_full_i  (q_full),
    .q_push_o  (fe_push),
    .cmd_o     (fe_cmd)
  );

  kscu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .data_i  (fe_cmd),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  kscu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .res_pop_i   (pop),
    .res_valid_o (res_valid),
    .res_char_o  (char_out_o),
    .status_o    (bk_status)
  );

  assign full  = q_full;
  assign empty = !res_valid;

  `KSCU_ASSERT_IMP(a_count_range, 1'b1, bk_status.key_count <= LETTER_CNT, "key count overflow")
  `KSCU_ASSERT_IMP(a_no_pop_in_fill, bk_status.filling, !q_pop, "queue popped during fill sweep")
  `KSCU_ASSERT_IMP(a_fill_done, $fell(bk_status.filling), bk_status.complete, "sweep ended incomplete")
  `KSCU_ASSERT_NXT(a_msg_result, q_pop && (q_head.op == OP_MSG), !empty, "message lost its result")

endmodule
